### rtl/wtwd_pkg.sv
// Package for the windowed two-way dispatcher: outcome codes, register
// indexes, the result word layout and the xorshift32 step.
// Depends on nothing; used by windowed_two_way_dispatcher.
`default_nettype none

package wtwd_pkg;

  // Configuration port.
  localparam int unsigned CfgIndexWidth = 1;
  localparam int unsigned CfgDataWidth  = 32;
  localparam logic [CfgIndexWidth-1:0] RegWindowSize = 1'd0;
  localparam logic [CfgIndexWidth-1:0] RegSeedValue  = 1'd1;

  localparam int unsigned WindowWidth    = 16;
  localparam int unsigned SeedWidth      = 32;
  localparam int unsigned TotalWidth     = 32;
  localparam logic [WindowWidth-1:0] WindowReset = 16'd16;
  localparam logic [SeedWidth-1:0]   SeedReset   = 32'd1;

  typedef enum logic [1:0] {
    OutIdle          = 2'd0,
    OutWindowBlocked = 2'd1,
    OutEngineBlocked = 2'd2,
    OutDispatched    = 2'd3
  } outcome_e;

  // Result word, ready_to_source in the lowest bits, padded to whole bytes.
  typedef struct packed {
    logic                  pad;
    logic [TotalWidth-1:0] random_choice_total;
    logic [TotalWidth-1:0] engine_blocked_total;
    logic [TotalWidth-1:0] window_blocked_ready_total;
    logic [TotalWidth-1:0] window_blocked_total;
    logic [TotalWidth-1:0] dispatched_total;
    logic                  random_used;
    outcome_e              outcome;
    logic                  chosen_engine;
    logic                  issue_engine1;
    logic                  issue_engine0;
    logic                  ready_to_source;
  } result_t;

  localparam int unsigned ResultWidth = $bits(result_t);

  // One step of xorshift32 with shifts 13, 17 and 5.
  function automatic logic [SeedWidth-1:0] xorshift_next(input logic [SeedWidth-1:0] s);
    logic [SeedWidth-1:0] a;
    logic [SeedWidth-1:0] b;
    a = s ^ (s << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

`default_nettype wire

### rtl/windowed_two_way_dispatcher.sv
// Windowed two-way dispatcher: one decision per input transfer, registered in
// and out. The input register and then the result register lie between input
// transfer and result transfer; one transfer is taken every cycle while the result side keeps up.
// The random state and the five counters update in the cycle that the item
// leaves the input register. Reset clears the counters, sets the window to 16
// and the random state to 1. Depends on wtwd_pkg.
`default_nettype none

module windowed_two_way_dispatcher #(
  parameter int unsigned ID_WIDTH      = 32,
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,

  input  wire logic                                 cfg_we_i,
  input  wire logic [wtwd_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  wire logic [wtwd_pkg::CfgDataWidth-1:0]    cfg_wdata_i,

  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  // request_valid, request_id, window_base, engine0_ready, engine1_ready
  input  wire logic [((2*ID_WIDTH+3+7)/8)*8-1:0]    s_axis_tdata,

  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // ready_to_source, issue_engine0, issue_engine1, chosen_engine, outcome,
  // random_used, dispatched_total, window_blocked_total,
  // window_blocked_ready_total, engine_blocked_total, random_choice_total
  output      logic [wtwd_pkg::ResultWidth-1:0]     m_axis_tdata
);

  localparam int unsigned InBits  = 2 * ID_WIDTH + 3;
  localparam int unsigned IdLo    = 1;
  localparam int unsigned BaseLo  = 1 + ID_WIDTH;
  localparam int unsigned Rdy0Bit = 1 + 2 * ID_WIDTH;
  localparam int unsigned Rdy1Bit = 2 + 2 * ID_WIDTH;
  localparam int unsigned CmpWidth =
      (ID_WIDTH > wtwd_pkg::WindowWidth) ? ID_WIDTH : wtwd_pkg::WindowWidth;

  // Configuration and state.
  logic [wtwd_pkg::WindowWidth-1:0] window_q;
  logic [wtwd_pkg::SeedWidth-1:0]   rnd_q, rnd_d;
  logic [COUNTER_WIDTH-1:0] disp_q, disp_d;
  logic [COUNTER_WIDTH-1:0] wblk_q, wblk_d;
  logic [COUNTER_WIDTH-1:0] wblk_rdy_q, wblk_rdy_d;
  logic [COUNTER_WIDTH-1:0] eblk_q, eblk_d;
  logic [COUNTER_WIDTH-1:0] rchoice_q, rchoice_d;

  // Input and result registers.
  logic              in_valid_q;
  logic [InBits-1:0] in_data_q;
  logic              out_valid_q;
  wtwd_pkg::result_t out_data_q;
  wtwd_pkg::result_t res;

  logic advance;

  // Decoded fields.
  logic                req_valid;
  logic [ID_WIDTH-1:0] req_id;
  logic [ID_WIDTH-1:0] win_base;
  logic [ID_WIDTH-1:0] id_diff;
  logic                rdy0, rdy1, both_rdy;
  logic                sel, sel_rdy, credit, go;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign req_valid = in_data_q[0];
  assign req_id    = in_data_q[IdLo +: ID_WIDTH];
  assign win_base  = in_data_q[BaseLo +: ID_WIDTH];
  assign rdy0      = in_data_q[Rdy0Bit];
  assign rdy1      = in_data_q[Rdy1Bit];
  assign both_rdy  = rdy0 && rdy1;
  assign id_diff   = req_id - win_base;

  always_comb begin
    sel     = both_rdy ? rnd_q[0] : !rdy0;
    sel_rdy = sel ? rdy1 : rdy0;
    // No wraparound: an id below the base never has credit.
    credit  = (req_id >= win_base) && (CmpWidth'(id_diff) < CmpWidth'(window_q));
    go      = credit && sel_rdy;

    disp_d     = disp_q;
    wblk_d     = wblk_q;
    wblk_rdy_d = wblk_rdy_q;
    eblk_d     = eblk_q;
    rchoice_d  = rchoice_q;
    rnd_d      = rnd_q;

    res                 = '0;
    res.ready_to_source = go;
    res.chosen_engine   = sel;
    res.outcome         = wtwd_pkg::OutIdle;

    if (req_valid) begin
      if (!credit) begin
        res.outcome = wtwd_pkg::OutWindowBlocked;
        wblk_d      = wblk_q + COUNTER_WIDTH'(1);
        if (rdy0 || rdy1) begin
          wblk_rdy_d = wblk_rdy_q + COUNTER_WIDTH'(1);
        end
      end else if (!sel_rdy) begin
        res.outcome = wtwd_pkg::OutEngineBlocked;
        eblk_d      = eblk_q + COUNTER_WIDTH'(1);
      end else begin
        res.outcome       = wtwd_pkg::OutDispatched;
        res.issue_engine0 = !sel;
        res.issue_engine1 = sel;
        disp_d            = disp_q + COUNTER_WIDTH'(1);
        if (both_rdy) begin
          res.random_used = 1'b1;
          rchoice_d       = rchoice_q + COUNTER_WIDTH'(1);
          rnd_d           = wtwd_pkg::xorshift_next(rnd_q);
        end
      end
    end

    res.dispatched_total           = wtwd_pkg::TotalWidth'(disp_d);
    res.window_blocked_total       = wtwd_pkg::TotalWidth'(wblk_d);
    res.window_blocked_ready_total = wtwd_pkg::TotalWidth'(wblk_rdy_d);
    res.engine_blocked_total       = wtwd_pkg::TotalWidth'(eblk_d);
    res.random_choice_total        = wtwd_pkg::TotalWidth'(rchoice_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= wtwd_pkg::WindowReset;
      rnd_q       <= wtwd_pkg::SeedReset;
      disp_q      <= '0;
      wblk_q      <= '0;
      wblk_rdy_q  <= '0;
      eblk_q      <= '0;
      rchoice_q   <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        disp_q      <= disp_d;
        wblk_q      <= wblk_d;
        wblk_rdy_q  <= wblk_rdy_d;
        eblk_q      <= eblk_d;
        rchoice_q   <= rchoice_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      // A seed write loads the random state at once. A zero seed would lock
      // the generator, so it loads one instead.
      if (cfg_we_i && (cfg_index_i == wtwd_pkg::RegSeedValue)) begin
        rnd_q <= (cfg_wdata_i[wtwd_pkg::SeedWidth-1:0] != '0) ?
                 cfg_wdata_i[wtwd_pkg::SeedWidth-1:0] : wtwd_pkg::SeedReset;
      end else if (advance) begin
        rnd_q <= rnd_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          wtwd_pkg::RegWindowSize: begin
            window_q <= cfg_wdata_i[wtwd_pkg::WindowWidth-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata[InBits-1:0];
    end
    if (advance) begin
      out_data_q <= res;
    end
  end

  a_rnd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_q != '0)
    else $error("random state became zero");

  a_issue_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q.issue_engine0 && out_data_q.issue_engine1))
    else $error("request issued to both engines");

  a_issue_dispatched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_data_q.issue_engine0 || out_data_q.issue_engine1)
    |-> out_data_q.outcome == wtwd_pkg::OutDispatched)
    else $error("issue without dispatch outcome");

  a_rnd_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.random_used && !cfg_we_i |=> rnd_q != $past(rnd_q))
    else $error("random state did not advance after a random choice");

  a_disp_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.outcome == wtwd_pkg::OutDispatched
    |=> disp_q == $past(disp_q) + COUNTER_WIDTH'(1))
    else $error("dispatch counter did not step");

endmodule

`default_nettype wire
